### rtl/nltsc_pkg.sv
// Shared types, constants and helpers for the length-prefix to start-code converter.
`default_nettype none

package nltsc_pkg;

	// Start code 00 00 00 01 is four bytes long.
	localparam int unsigned StartCodeBytes = 4;
	localparam logic [2:0]  LfbReset       = 3'd4;
	localparam logic [31:0] MaxSampleReset = 32'd65536;
	localparam logic [31:0] CapacityReset  = 32'd65536;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_LENGTH_FIELD_BYTES = 2'd0,
		CFG_MAX_SAMPLE_BYTES   = 2'd1,
		CFG_OUT_CAPACITY       = 2'd2
	} cfg_index_t;

	// Parsing phase of the current sample.
	typedef enum logic [1:0] {
		PH_LEN = 2'd0,
		PH_PAY = 2'd1,
		PH_BAD = 2'd2
	} phase_t;

	// Configuration as seen by the parser.
	typedef struct packed {
		logic [2:0]  length_field_bytes;
		logic [31:0] max_sample_bytes;
		logic [31:0] out_capacity;
	} cfg_t;

	// Results caused by one input byte: a start code burst, one payload byte or none,
	// optionally followed by the end-of-sample status.
	typedef struct packed {
		logic        start_code;
		logic        data;
		logic        status;
		logic        bad;
		logic [7:0]  data_byte;
		logic [31:0] length;
	} burst_t;

	// Prefix size clamped into 1..4.
	function automatic logic [2:0] prefix_size(input logic [2:0] lfb);
		logic [2:0] size;
		if (lfb == 3'd0) begin
			size = 3'd1;
		end else if (lfb > 3'd4) begin
			size = 3'd4;
		end else begin
			size = lfb;
		end
		return size;
	endfunction

endpackage

`default_nettype wire

### rtl/nltsc_core.sv
// Per-sample parser: tracks prefix and payload state and describes each byte's results.
`default_nettype none

module nltsc_core import nltsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        sample_end,
	input  wire cfg_t        cfg,
	output burst_t           desc
);

	phase_t      phase_q, phase_d;
	logic [2:0]  left_q, left_d;
	logic [31:0] accum_q, accum_d;
	logic [31:0] payload_q, payload_d;
	logic [31:0] in_count_q, in_count_d;
	logic [31:0] out_count_q, out_count_d;

	logic [2:0]  psize;
	logic [31:0] accum_shift;
	logic [2:0]  left_dec;
	logic [31:0] payload_dec;
	logic [33:0] need;
	logic        too_large;

	assign psize       = prefix_size(cfg.length_field_bytes);
	assign accum_shift = {accum_q[23:0], data_byte};
	assign left_dec    = (left_q != 3'd0) ? left_q - 3'd1 : left_q;
	assign payload_dec = (payload_q != 32'd0) ? payload_q - 32'd1 : payload_q;
	assign need        = {2'b00, out_count_q} + 34'(StartCodeBytes) + {2'b00, accum_shift};
	assign too_large   = (in_count_q == cfg.max_sample_bytes) ||
	                     (in_count_q == cfg.out_capacity);

	// Next sample state and the results caused by the incoming byte.
	always_comb begin
		phase_d     = phase_q;
		left_d      = left_q;
		accum_d     = accum_q;
		payload_d   = payload_q;
		in_count_d  = in_count_q;
		out_count_d = out_count_q;
		desc        = '0;

		unique case (phase_q)
			PH_LEN, PH_PAY: begin
				if (too_large) begin
					phase_d = PH_BAD;
				end else begin
					in_count_d = in_count_q + 32'd1;
					if (phase_q == PH_LEN) begin
						accum_d = accum_shift;
						left_d  = left_dec;
						if (left_dec == 3'd0) begin
							accum_d = '0;
							left_d  = psize;
							if (accum_shift != 32'd0) begin
								if (need > {2'b00, cfg.out_capacity}) begin
									phase_d = PH_BAD;
								end else begin
									desc.start_code = 1'b1;
									out_count_d     = out_count_q + 32'(StartCodeBytes);
									payload_d       = accum_shift;
									phase_d         = PH_PAY;
								end
							end
						end
					end else begin
						desc.data      = 1'b1;
						desc.data_byte = data_byte;
						out_count_d    = out_count_q + 32'd1;
						payload_d      = payload_dec;
						if (payload_dec == 32'd0) begin
							phase_d = PH_LEN;
							left_d  = psize;
							accum_d = '0;
						end
					end
				end
			end
			default: begin
				// A bad sample absorbs bytes until its end.
			end
		endcase

		// End of sample: report status, then return to the initial state.
		if (sample_end) begin
			desc.status = 1'b1;
			desc.bad    = !((phase_d == PH_LEN) && (left_d == psize) && (accum_d == 32'd0));
			desc.length = out_count_d;
			phase_d     = PH_LEN;
			left_d      = psize;
			accum_d     = '0;
			payload_d   = '0;
			in_count_d  = '0;
			out_count_d = '0;
		end
	end

	// Sample state registers, updated on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEN;
			left_q      <= LfbReset;
			accum_q     <= '0;
			payload_q   <= '0;
			in_count_q  <= '0;
			out_count_q <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			left_q      <= left_d;
			accum_q     <= accum_d;
			payload_q   <= payload_d;
			in_count_q  <= in_count_d;
			out_count_q <= out_count_d;
		end
	end

`ifndef SYNTHESIS
	// A prefix countdown is always reloaded before it can reach zero.
	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		left_q != 3'd0)
		else $error("prefix countdown reached zero in the register");

	// While copying a payload there is always at least one byte still to copy.
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAY) |-> (payload_q != 32'd0))
		else $error("payload phase with nothing left to copy");

	// The last byte of a sample clears the byte counters.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sample_end) |=> (in_count_q == 32'd0 && out_count_q == 32'd0))
		else $error("sample counters not cleared at end of sample");
`endif

endmodule

`default_nettype wire

### rtl/nltsc_emit.sv
// Result register and sequencer that plays out each byte's results one per cycle while the output is not stalled.
`default_nettype none

module nltsc_emit import nltsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire burst_t      desc,
	output logic             in_stall,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             is_status,
	output logic             malformed,
	output logic [31:0]      out_length,
	output logic             run_last
);

	logic        pend_q;
	burst_t      burst_q;
	logic [2:0]  idx_q;

	logic [2:0]  n_data;
	logic [2:0]  n_total;
	logic        taken;
	logic        finish;
	logic        load;

	// Number of data results and of all results in the pending request.
	assign n_data  = burst_q.start_code ? 3'(StartCodeBytes) :
	                 (burst_q.data ? 3'd1 : 3'd0);
	assign n_total = n_data + {2'b00, burst_q.status};

	assign out_valid = pend_q;
	assign taken     = pend_q && !out_stall;
	assign run_last  = (idx_q == n_total - 3'd1);
	assign finish    = taken && run_last;
	assign in_stall  = pend_q && !finish;
	assign load      = in_valid && !in_stall &&
	                   (desc.start_code || desc.data || desc.status);

	// Field selection for the current result.
	always_comb begin
		out_byte   = '0;
		is_status  = 1'b0;
		malformed  = 1'b0;
		out_length = '0;
		if (idx_q == n_data) begin
			is_status  = 1'b1;
			malformed  = burst_q.bad;
			out_length = burst_q.length;
		end else if (burst_q.start_code) begin
			out_byte = (idx_q == 3'(StartCodeBytes - 1)) ? 8'h01 : 8'h00;
		end else begin
			out_byte = burst_q.data_byte;
		end
	end

	// Pending request and result index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			pend_q <= 1'b1;
			idx_q  <= '0;
		end else if (finish) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (taken) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= desc;
		end
	end

`ifndef SYNTHESIS
	// The index never runs past the results of the pending request.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (idx_q < n_total))
		else $error("result index beyond pending request");

	// A status result is always the last one caused by its byte.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && is_status) |-> run_last)
		else $error("status result not marked last");

	// Finishing with nothing to load leaves the result register empty.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(finish && !load) |=> !pend_q)
		else $error("result register still busy after its last result");
`endif

endmodule

`default_nettype wire

### rtl/nal_length_to_start_code_top.sv
// A byte's first result is shown in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte that completes a prefix stalls the input while the result
// register plays out the start code and, when the byte also ends the sample, its status.
// Reset: arst_n clears the sample state, the pending result and the configuration registers to their defaults at once.
`default_nettype none

module nal_length_to_start_code_top import nltsc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        sample_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             is_status,
	output logic             malformed,
	output logic [31:0]      out_length,
	output logic             run_last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t   cfg_q;
	burst_t desc;
	logic   accept;

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_field_bytes <= LfbReset;
			cfg_q.max_sample_bytes   <= MaxSampleReset;
			cfg_q.out_capacity       <= CapacityReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LENGTH_FIELD_BYTES: cfg_q.length_field_bytes <= cfg_data[2:0];
				CFG_MAX_SAMPLE_BYTES:   cfg_q.max_sample_bytes   <= cfg_data;
				CFG_OUT_CAPACITY:       cfg_q.out_capacity       <= cfg_data;
				default: begin
					// Index beyond the register list is ignored.
				end
			endcase
		end
	end

	nltsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.sample_end (sample_end),
		.cfg        (cfg_q),
		.desc       (desc)
	);

	nltsc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.desc       (desc),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_status  (is_status),
		.malformed  (malformed),
		.out_length (out_length),
		.run_last   (run_last)
	);

endmodule

`default_nettype wire
